// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the moving average block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge while reset is released.
`define WCMA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising clock edge, also during reset.
`define WCMA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/wcma_pkg.sv -----
// ----------------------------------------------------------------------------
// wcma_pkg
// Sizes, types and sequencer states of the weighted centered moving average.
// ----------------------------------------------------------------------------
package wcma_pkg;

    // Window geometry.
    localparam int HALF   = 8;
    localparam int WIN    = 2 * HALF + 1;
    localparam int IDX_W  = $clog2(WIN);
    localparam int SEEN_W = $clog2(WIN + 1);
    localparam int LAG_W  = $clog2(HALF + 1);

    // Field widths fixed by the item format.
    localparam int SMP_W      = 16;
    localparam int WGT_W      = 16;
    localparam int TAP_IDX_W  = 5;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 16;

    // Arithmetic widths.
    localparam int PROD_W = SMP_W + WGT_W + 1;
    localparam int ACC_W  = PROD_W + IDX_W;
    localparam int WSUM_W = WGT_W + IDX_W;
    localparam int Q_W    = SMP_W + 1;
    localparam int DSH_W  = WSUM_W + Q_W - 1;
    localparam int STEP_W = $clog2(Q_W);

    // Request kinds carried in tuser.
    localparam logic REQ_WEIGHT = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef logic signed [SMP_W-1:0] smp_t;
    typedef logic        [WGT_W-1:0] wgt_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_START,
        S_DIV,
        S_EMIT
    } state_t;

endpackage

// ----- hdl/wcma_cell.sv -----
// ----------------------------------------------------------------------------
// wcma_cell
// One window tap: holds a sample that moves toward the oldest end on each
// new stream sample, and the weight loaded for this tap position.
// ----------------------------------------------------------------------------
module wcma_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          shift_en,
    input  wcma_pkg::smp_t smp_in,
    input  logic          wr_en,
    input  wcma_pkg::wgt_t wgt_in,
    output wcma_pkg::smp_t smp_out,
    output wcma_pkg::wgt_t wgt_out
);

    wcma_pkg::smp_t smp_reg;
    wcma_pkg::wgt_t wgt_reg;

    // The sample moves to the neighbor when a new sample enters the chain.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            smp_reg <= smp_in;
        end
    end

    // Weights start at zero and change only on a weight load.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wgt_reg <= '0;
        end else if (wr_en) begin
            wgt_reg <= wgt_in;
        end
    end

    assign smp_out = smp_reg;
    assign wgt_out = wgt_reg;

endmodule

// ----- hdl/wcma_div.sv -----
// ----------------------------------------------------------------------------
// wcma_div
// Restoring divider, one quotient bit per cycle. Divides the signed weighted
// sum by the weight sum, truncates toward zero and saturates to 16 bits.
// ----------------------------------------------------------------------------
module wcma_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [wcma_pkg::ACC_W-1:0]    dividend,
    input  logic        [wcma_pkg::WSUM_W-1:0]   divisor,
    output logic                                 done,
    output wcma_pkg::smp_t                       mean
);

    logic [wcma_pkg::ACC_W-1:0]  rem_reg,  rem_next;
    logic [wcma_pkg::DSH_W-1:0]  dsh_reg,  dsh_next;
    logic [wcma_pkg::Q_W-1:0]    q_reg,    q_next;
    logic [wcma_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        neg_reg,  neg_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [wcma_pkg::ACC_W-1:0]  trial;
    logic                        fits;
    logic [wcma_pkg::Q_W-1:0]    q_neg;

    // One trial subtraction of the shifted divisor per cycle.
    always_comb begin
        trial     = rem_reg - wcma_pkg::ACC_W'(dsh_reg);
        fits      = rem_reg >= wcma_pkg::ACC_W'(dsh_reg);
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            neg_next  = dividend[wcma_pkg::ACC_W-1];
            rem_next  = dividend[wcma_pkg::ACC_W-1] ? (-dividend) : dividend;
            dsh_next  = {divisor, {(wcma_pkg::Q_W-1){1'b0}}};
            q_next    = '0;
            step_next = wcma_pkg::STEP_W'(wcma_pkg::Q_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = trial;
            end
            q_next    = {q_reg[wcma_pkg::Q_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        step_reg <= step_next;
        neg_reg  <= neg_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Apply the sign and clamp the magnitude to the 16-bit range.
    always_comb begin
        q_neg = -q_reg;
        if (neg_reg) begin
            if (q_reg > wcma_pkg::Q_W'(32768)) begin
                mean = 16'sh8000;
            end else begin
                mean = q_neg[wcma_pkg::SMP_W-1:0];
            end
        end else begin
            if (q_reg > wcma_pkg::Q_W'(32767)) begin
                mean = 16'sh7fff;
            end else begin
                mean = q_reg[wcma_pkg::SMP_W-1:0];
            end
        end
    end

    assign done = done_reg;

endmodule

// ----- hdl/weighted_centered_moving_average.sv -----
// Items are taken one at a time; a weight load completes when it is accepted,
// while a sample that yields k results holds the input for the 17-step tap walk
// of the shared multiply-accumulate and the 17-step divider per result.
// Reset: aresetn low clears all weights, the stream count and the output valid flag.
// ----------------------------------------------------------------------------
// weighted_centered_moving_average
// Centered weighted moving average with weight renormalization at the stream
// edges, built as a chain of tap cells with a shared MAC and divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module weighted_centered_moving_average (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tap_index [4:0], tap_weight [20:5], sample [36:21], zero fill [39:37]
    input  logic [wcma_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // mean [15:0]
    output logic [wcma_pkg::M_TDATA_W-1:0]  m_tdata,
    // zero_weight
    output logic                            m_tuser,
    output logic                            m_tlast
);

    localparam int IW = wcma_pkg::IDX_W;

    wcma_pkg::state_t state_reg, state_next;

    logic [IW-1:0]                    tap_reg, tap_next;
    logic [wcma_pkg::LAG_W-1:0]       lag_reg, lag_next;
    logic                             flush_reg, flush_next;
    logic [wcma_pkg::SEEN_W-1:0]      seen_reg, seen_next;
    logic signed [wcma_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [wcma_pkg::WSUM_W-1:0]      wsum_reg, wsum_next;
    logic signed [wcma_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [wcma_pkg::WGT_W-1:0]       pw_reg, pw_next;
    logic                             pv_reg, pv_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [wcma_pkg::M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                             m_tuser_reg, m_tuser_next;
    logic                             m_tlast_reg, m_tlast_next;

    logic                             in_xfer;
    logic                             smp_xfer;
    logic                             wgt_xfer;
    logic [wcma_pkg::TAP_IDX_W-1:0]   in_tap;
    wcma_pkg::wgt_t                   in_wgt;
    wcma_pkg::smp_t                   in_smp;
    logic [wcma_pkg::SEEN_W-1:0]      seen_inc;
    logic [wcma_pkg::LAG_W-1:0]       flush_top;
    logic                             out_free;
    logic                             div_start;
    logic                             div_done;
    wcma_pkg::smp_t                   div_mean;

    wcma_pkg::smp_t                   cell_smp [wcma_pkg::WIN];
    wcma_pkg::wgt_t                   cell_wgt [wcma_pkg::WIN];

    logic [IW:0]                      lag_sum;
    logic [IW:0]                      tap_ext;
    logic [IW:0]                      tap_dist;
    logic [IW:0]                      rd_full;
    logic                             tap_valid;
    wcma_pkg::smp_t                   smp_sel;
    wcma_pkg::wgt_t                   wgt_sel;

    // Unpack the input transfer.
    assign in_xfer  = s_tvalid && s_tready;
    assign smp_xfer = in_xfer && (s_tuser == wcma_pkg::REQ_SAMPLE);
    assign wgt_xfer = in_xfer && (s_tuser == wcma_pkg::REQ_WEIGHT);
    assign in_tap   = s_tdata[4:0];
    assign in_wgt   = s_tdata[20:5];
    assign in_smp   = s_tdata[36:21];

    // Row of tap cells; the newest sample enters at the top end.
    for (genvar i = 0; i < wcma_pkg::WIN; i++) begin : g_cell
        wcma_pkg::smp_t chain_in;
        logic           wr_en;
        if (i == wcma_pkg::WIN - 1) begin : g_top
            assign chain_in = in_smp;
        end else begin : g_mid
            assign chain_in = cell_smp[i+1];
        end
        assign wr_en = wgt_xfer && (int'(in_tap) == i);
        wcma_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (smp_xfer),
            .smp_in   (chain_in),
            .wr_en    (wr_en),
            .wgt_in   (in_wgt),
            .smp_out  (cell_smp[i]),
            .wgt_out  (cell_wgt[i])
        );
    end

    // Shared divider.
    wcma_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (wsum_reg),
        .done     (div_done),
        .mean     (div_mean)
    );

    // Stream count after this sample, saturating at the window size.
    assign seen_inc  = (seen_reg < wcma_pkg::SEEN_W'(wcma_pkg::WIN)) ?
                       (seen_reg + 1'b1) : seen_reg;
    assign flush_top = (seen_inc > wcma_pkg::SEEN_W'(wcma_pkg::HALF)) ?
                       wcma_pkg::LAG_W'(wcma_pkg::HALF) :
                       wcma_pkg::LAG_W'(seen_inc - 1'b1);
    assign out_free  = !m_tvalid_reg || m_tready;

    // Tap selection: weight t pairs with the sample lag + HALF - t back.
    always_comb begin
        lag_sum   = (IW+1)'(lag_reg) + (IW+1)'(wcma_pkg::HALF);
        tap_ext   = (IW+1)'(tap_reg);
        tap_dist  = lag_sum - tap_ext;
        rd_full   = (IW+1)'(wcma_pkg::WIN - 1) - tap_dist;
        tap_valid = (tap_ext <= lag_sum) && (tap_dist < (IW+1)'(seen_reg));
        wgt_sel   = cell_wgt[tap_reg];
        smp_sel   = tap_valid ? cell_smp[rd_full[IW-1:0]] : '0;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wcma_pkg::S_IDLE: begin
                if (smp_xfer && (s_tlast ||
                        seen_inc > wcma_pkg::SEEN_W'(wcma_pkg::HALF))) begin
                    state_next = wcma_pkg::S_MAC;
                end
            end
            wcma_pkg::S_MAC: begin
                if (tap_reg == IW'(wcma_pkg::WIN - 1)) begin
                    state_next = wcma_pkg::S_DRAIN;
                end
            end
            wcma_pkg::S_DRAIN: state_next = wcma_pkg::S_START;
            wcma_pkg::S_START: state_next = wcma_pkg::S_DIV;
            wcma_pkg::S_DIV: begin
                if (div_done) begin
                    state_next = wcma_pkg::S_EMIT;
                end
            end
            wcma_pkg::S_EMIT: begin
                if (out_free) begin
                    if (flush_reg && lag_reg != '0) begin
                        state_next = wcma_pkg::S_MAC;
                    end else begin
                        state_next = wcma_pkg::S_IDLE;
                    end
                end
            end
            default: state_next = wcma_pkg::S_IDLE;
        endcase
    end

    // State-decoded controls.
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            wcma_pkg::S_IDLE:  s_tready  = 1'b1;
            wcma_pkg::S_START: div_start = 1'b1;
            default: begin
                s_tready  = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    // Datapath: stream count, MAC walk, result hand-off to the output stage.
    always_comb begin
        tap_next      = tap_reg;
        lag_next      = lag_reg;
        flush_next    = flush_reg;
        seen_next     = seen_reg;
        acc_next      = acc_reg;
        wsum_next     = wsum_reg;
        // Both factors are zero for a tap outside the stream.
        pw_next       = tap_valid ? wgt_sel : '0;
        prod_next     = smp_sel * $signed({1'b0, pw_next});
        pv_next       = (state_reg == wcma_pkg::S_MAC);
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        if (pv_reg) begin
            acc_next  = acc_reg + wcma_pkg::ACC_W'(prod_reg);
            wsum_next = wsum_reg + wcma_pkg::WSUM_W'(pw_reg);
        end

        if (smp_xfer) begin
            seen_next  = seen_inc;
            flush_next = s_tlast;
            lag_next   = s_tlast ? flush_top : wcma_pkg::LAG_W'(wcma_pkg::HALF);
            tap_next   = '0;
            acc_next   = '0;
            wsum_next  = '0;
        end

        if (state_reg == wcma_pkg::S_MAC) begin
            tap_next = tap_reg + 1'b1;
        end

        if (state_reg == wcma_pkg::S_EMIT && out_free) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = (wsum_reg == '0);
            m_tdata_next  = (wsum_reg == '0) ? '0 : div_mean;
            m_tlast_next  = flush_reg && (lag_reg == '0);
            tap_next      = '0;
            acc_next      = '0;
            wsum_next     = '0;
            if (flush_reg) begin
                if (lag_reg == '0) begin
                    seen_next = '0;
                end else begin
                    lag_next = lag_reg - 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        tap_reg     <= tap_next;
        lag_reg     <= lag_next;
        flush_reg   <= flush_next;
        acc_reg     <= acc_next;
        wsum_reg    <= wsum_next;
        prod_reg    <= prod_next;
        pw_reg      <= pw_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wcma_pkg::S_IDLE;
            seen_reg     <= '0;
            pv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            seen_reg     <= seen_next;
            pv_reg       <= pv_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Checks on the sequencer and result formatting.
    `WCMA_ASSERT(a_seen_range, aclk, aresetn, seen_reg <= wcma_pkg::SEEN_W'(wcma_pkg::WIN), "stream count beyond window")
    `WCMA_ASSERT(a_zero_mean, aclk, aresetn, (m_tvalid && m_tuser) |-> (m_tdata == '0), "zero weight result with nonzero mean")
    `WCMA_ASSERT(a_walk_end, aclk, aresetn, (state_reg == wcma_pkg::S_MAC && tap_reg == IW'(wcma_pkg::WIN - 1)) |=> (state_reg == wcma_pkg::S_DRAIN), "tap walk overran the window")

endmodule
